// ===== sv/cmvc_pkg.sv =====
// Shared types, constants and lookup functions of the bus volume calculator.
`timescale 1ns / 1ps
package cmvc_pkg;

  localparam int ONE_Q14       = 16384;
  localparam int HALF_Q14      = 8192;
  localparam int COMP_GAIN_Q14 = 5698;
  localparam int COMP_OFFS_Q14 = 5343;
  localparam int NUM_OUT       = 6;
  localparam int NUM_GAIN      = 6;
  localparam int VOL_W         = 18;
  localparam int CFG_W         = 48;

  typedef logic [14:0] lvl_t;
  typedef logic [VOL_W-1:0] vol_t;

  typedef enum logic [1:0] {
    PART_SKIP = 2'd0,
    PART_ADD  = 2'd1,
    PART_POW  = 2'd2
  } part_op_t;

  typedef struct packed {
    part_op_t snd;
    part_op_t eff;
    part_op_t chn;
  } row_ops_t;

  typedef enum logic [2:0] {
    SRC_NONE    = 3'd0,
    SRC_PAN     = 3'd1,
    SRC_FX      = 3'd2,
    SRC_SUR     = 3'd3,
    SRC_UNITY   = 3'd4,
    SRC_INV_PAN = 3'd5,
    SRC_INV_FX  = 3'd6,
    SRC_INV_SUR = 3'd7
  } src_t;

  typedef enum logic [1:0] {
    MODE_CENTRE = 2'd0,
    MODE_NO_SUR = 2'd1,
    MODE_FULL   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CFG_SOUND_LEVELS   = 3'd0,
    CFG_CHANNEL_LEVELS = 3'd1,
    CFG_POWER_WEIGHTS  = 3'd2,
    CFG_CALC_TYPES     = 3'd3,
    CFG_MIX_SLOTS      = 3'd4,
    CFG_VOLUME_GAIN    = 3'd5,
    CFG_CHANNEL_LEVEL  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    lvl_t pan;
    lvl_t fx;
    lvl_t sur;
  } levels_t;

  typedef struct packed {
    lvl_t [NUM_GAIN-1:0] lin;
    lvl_t [NUM_GAIN-1:0] sine;
    lvl_t [NUM_GAIN-1:0] csine;
  } gains_t;

  function automatic row_ops_t calc_row(logic [4:0] row);
    row_ops_t r;
    case (row)
      5'd1, 5'd2: r = '{PART_SKIP, PART_SKIP, PART_ADD};
      5'd3, 5'd6: r = '{PART_SKIP, PART_ADD,  PART_SKIP};
      5'd4:       r = '{PART_SKIP, PART_ADD,  PART_ADD};
      5'd5:       r = '{PART_SKIP, PART_ADD,  PART_POW};
      5'd7:       r = '{PART_SKIP, PART_POW,  PART_ADD};
      5'd8:       r = '{PART_SKIP, PART_POW,  PART_POW};
      5'd9, 5'd18: r = '{PART_ADD, PART_SKIP, PART_SKIP};
      5'd10:      r = '{PART_ADD,  PART_SKIP, PART_ADD};
      5'd11:      r = '{PART_ADD,  PART_SKIP, PART_POW};
      5'd12:      r = '{PART_ADD,  PART_ADD,  PART_SKIP};
      5'd13:      r = '{PART_ADD,  PART_ADD,  PART_ADD};
      5'd14:      r = '{PART_ADD,  PART_ADD,  PART_POW};
      5'd15:      r = '{PART_ADD,  PART_POW,  PART_SKIP};
      5'd16:      r = '{PART_ADD,  PART_POW,  PART_ADD};
      5'd17:      r = '{PART_ADD,  PART_POW,  PART_POW};
      5'd19:      r = '{PART_POW,  PART_SKIP, PART_ADD};
      5'd20:      r = '{PART_POW,  PART_SKIP, PART_POW};
      5'd21:      r = '{PART_POW,  PART_ADD,  PART_SKIP};
      5'd22:      r = '{PART_POW,  PART_ADD,  PART_ADD};
      5'd23:      r = '{PART_POW,  PART_ADD,  PART_POW};
      5'd24:      r = '{PART_POW,  PART_POW,  PART_SKIP};
      5'd25:      r = '{PART_POW,  PART_POW,  PART_ADD};
      5'd26:      r = '{PART_POW,  PART_POW,  PART_POW};
      default:    r = '{PART_SKIP, PART_SKIP, PART_SKIP};
    endcase
    return r;
  endfunction

  // gain lane: pan, fx, sur, then their complements
  function automatic logic [2:0] gain_lane(src_t s);
    logic [2:0] k;
    case (s)
      SRC_PAN:     k = 3'd0;
      SRC_FX:      k = 3'd1;
      SRC_SUR:     k = 3'd2;
      SRC_INV_PAN: k = 3'd3;
      SRC_INV_FX:  k = 3'd4;
      SRC_INV_SUR: k = 3'd5;
      default:     k = 3'd0;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/cmvc_in_if.sv =====
// Input channel: valid/ready handshake with one voice's oscillator levels.
`timescale 1ns / 1ps
interface cmvc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] osc_volume;
  logic signed [15:0] osc_pan;
  logic signed [15:0] osc_fxmix;
  logic signed [15:0] osc_surround;

  modport source (output valid, osc_volume, osc_pan, osc_fxmix, osc_surround, input ready);
  modport sink (input valid, osc_volume, osc_pan, osc_fxmix, osc_surround, output ready);
endinterface

// ===== sv/cmvc_out_if.sv =====
// Result channel: valid/ready handshake with six bus volumes.
`timescale 1ns / 1ps
interface cmvc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] bus_volume_0;
  logic [15:0] bus_volume_1;
  logic [15:0] bus_volume_2;
  logic [15:0] bus_volume_3;
  logic [15:0] bus_volume_4;
  logic [15:0] bus_volume_5;

  modport source (output valid, bus_volume_0, bus_volume_1, bus_volume_2, bus_volume_3,
                  bus_volume_4, bus_volume_5, input ready);
  modport sink (input valid, bus_volume_0, bus_volume_1, bus_volume_2, bus_volume_3,
                bus_volume_4, bus_volume_5, output ready);
endinterface

// ===== sv/cmvc_level.sv =====
// Two-stage combine of pan, fx-mix and surround parts, clamp, and voice volume.
`timescale 1ns / 1ps
module cmvc_level
  import cmvc_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] osc_volume,
  input  logic [15:0] osc_pan,
  input  logic [15:0] osc_fxmix,
  input  logic [15:0] osc_surround,
  input  logic [47:0] sound_levels,
  input  logic [47:0] channel_levels,
  input  logic [47:0] power_weights,
  input  logic [16:0] calc_types,
  input  logic [15:0] volume_gain,
  output levels_t     lv,
  output vol_t        vol
);

  logic signed [19:0] term_r [3][3];
  logic signed [19:0] term_nxt [3][3];
  vol_t    vol1_r, vol2_r;
  levels_t lv_r, lv_nxt;
  logic [31:0] vol_prod;

  always_comb begin
    logic [15:0] val;
    logic signed [16:0] v;
    logic signed [15:0] w;
    logic signed [32:0] prod;
    row_ops_t ops;
    part_op_t op;
    for (int q = 0; q < 3; q++) begin
      ops = calc_row(calc_types[5*q +: 5]);
      for (int p = 0; p < 3; p++) begin
        if (p == 0) begin
          val = sound_levels[16*q +: 16];
          op  = ops.snd;
        end else if (p == 2) begin
          val = channel_levels[16*q +: 16];
          op  = ops.chn;
        end else begin
          val = (q == 0) ? osc_pan : ((q == 1) ? osc_fxmix : osc_surround);
          op  = ops.eff;
        end
        v    = $signed({val[15], val}) - ((q == 0) ? 17'sd8192 : 17'sd0);
        w    = $signed(power_weights[16*p +: 16]);
        prod = v * w;
        case (op)
          PART_ADD: term_nxt[q][p] = {{3{v[16]}}, v};
          PART_POW: term_nxt[q][p] = {prod[32], prod[32:14]};
          default:  term_nxt[q][p] = '0;
        endcase
      end
    end
  end

  assign vol_prod = volume_gain * osc_volume;

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= term_nxt;
      vol1_r <= vol_prod[31:14];
      vol2_r <= vol1_r;
      lv_r   <= lv_nxt;
    end
  end

  always_comb begin
    logic signed [21:0] sum;
    lvl_t c [3];
    for (int q = 0; q < 3; q++) begin
      sum = 22'(term_r[q][0]) + 22'(term_r[q][1]) + 22'(term_r[q][2])
          + ((q == 0) ? 22'sd8192 : 22'sd0);
      if (sum < 0) c[q] = '0;
      else if (sum > 22'sd16384) c[q] = 15'(ONE_Q14);
      else c[q] = sum[14:0];
    end
    lv_nxt.pan = c[0];
    lv_nxt.fx  = c[1];
    lv_nxt.sur = c[2];
    case (calc_types[16:15])
      MODE_CENTRE: begin
        lv_nxt.pan = 15'(HALF_Q14);
        lv_nxt.sur = '0;
      end
      MODE_NO_SUR: lv_nxt.sur = '0;
      default: ;
    endcase
  end

  assign lv  = lv_r;
  assign vol = vol2_r;

endmodule

// ===== sv/cmvc_sine.sv =====
// Three-stage gain lanes: complements, compressed argument, quarter-wave sine lookup.
`timescale 1ns / 1ps
module cmvc_sine
  import cmvc_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic    clk,
  input  logic    en,
  input  levels_t lv,
  output gains_t  gains
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = 16 + IW;

  // advance one odd power of the series: m * t^2 in Q30
  function automatic longint unsigned sq_step(longint unsigned m, longint unsigned t);
    return (((m * t) >> 30) * t) >> 30;
  endfunction

  lvl_t sine_tab [SINE_TABLE_DEPTH+1];

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tab
    localparam longint unsigned T  = (64'(g) * 64'd1686629713) / SINE_TABLE_DEPTH;
    localparam longint unsigned M1 = sq_step(T, T) / 64'd6;
    localparam longint unsigned M2 = sq_step(M1, T) / 64'd20;
    localparam longint unsigned M3 = sq_step(M2, T) / 64'd42;
    localparam longint unsigned M4 = sq_step(M3, T) / 64'd72;
    localparam longint unsigned M5 = sq_step(M4, T) / 64'd110;
    localparam longint unsigned M6 = sq_step(M5, T) / 64'd156;
    localparam longint S = longint'(T) - longint'(M1) + longint'(M2) - longint'(M3)
                         + longint'(M4) - longint'(M5) + longint'(M6);
    localparam longint unsigned SU = (S < 0) ? 64'd0 : $unsigned(S);
    localparam lvl_t ENTRY = lvl_t'((SU + 64'd32768) >> 16);
    assign sine_tab[g] = ENTRY;
  end

  lvl_t s_r [NUM_GAIN];
  lvl_t s2_r [NUM_GAIN];
  lvl_t comp_r [NUM_GAIN];
  logic [IW-1:0] is_r [NUM_GAIN];
  logic [IW-1:0] ic_r [NUM_GAIN];
  lvl_t s_nxt [NUM_GAIN];
  lvl_t comp_nxt [NUM_GAIN];
  logic [IW-1:0] is_nxt [NUM_GAIN];
  logic [IW-1:0] ic_nxt [NUM_GAIN];
  gains_t gains_r, gains_nxt;

  always_comb begin
    lvl_t b;
    logic [28:0] cp;
    for (int k = 0; k < NUM_GAIN; k++) begin
      b = (k == 0 || k == 3) ? lv.pan : ((k == 1 || k == 4) ? lv.fx : lv.sur);
      s_nxt[k]    = (k < 3) ? b : lvl_t'(15'(ONE_Q14) - b);
      cp          = 29'(s_nxt[k]) * 29'(COMP_GAIN_Q14) + 29'(HALF_Q14);
      comp_nxt[k] = lvl_t'(cp[28:14]) + 15'(COMP_OFFS_Q14);
    end
  end

  always_comb begin
    logic [PW-1:0] ps, pc;
    for (int k = 0; k < NUM_GAIN; k++) begin
      ps = PW'(s_r[k]) * PW'(SINE_TABLE_DEPTH) + PW'(HALF_Q14);
      pc = PW'(comp_r[k]) * PW'(SINE_TABLE_DEPTH) + PW'(HALF_Q14);
      is_nxt[k] = ps[14 +: IW];
      ic_nxt[k] = pc[14 +: IW];
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_GAIN; k++) begin
      gains_nxt.lin[k]   = s2_r[k];
      gains_nxt.sine[k]  = sine_tab[is_r[k]];
      gains_nxt.csine[k] = sine_tab[ic_r[k]];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r     <= s_nxt;
      comp_r  <= comp_nxt;
      s2_r    <= s_r;
      is_r    <= is_nxt;
      ic_r    <= ic_nxt;
      gains_r <= gains_nxt;
    end
  end

  assign gains = gains_r;

endmodule

// ===== sv/cmvc_slot.sv =====
// Three-stage bus slot: two scale laws, clamp, and channel level multiply.
`timescale 1ns / 1ps
module cmvc_slot
  import cmvc_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [6:0]  slot_cfg,
  input  gains_t      gains,
  input  vol_t        vol,
  input  logic [15:0] channel_level,
  output logic [15:0] bus_volume
);

  src_t sel1, sel2;
  lvl_t g1, g2;
  logic [32:0] p1;
  logic [32:0] p2;
  logic [30:0] p3;
  logic        on1_r, on2_r;
  vol_t        v1_r;
  lvl_t        g2_r;
  lvl_t        v2_r, v2_nxt;
  logic [15:0] out_r, out_nxt;

  assign sel1 = src_t'(slot_cfg[5:3]);
  assign sel2 = src_t'(slot_cfg[2:0]);

  always_comb begin
    case (sel1)
      SRC_NONE, SRC_UNITY:  g1 = 15'(ONE_Q14);
      SRC_FX, SRC_INV_FX:   g1 = gains.lin[gain_lane(sel1)];
      default:              g1 = gains.sine[gain_lane(sel1)];
    endcase
    case (sel2)
      SRC_NONE, SRC_UNITY:  g2 = 15'(ONE_Q14);
      SRC_FX, SRC_INV_FX:   g2 = gains.lin[gain_lane(sel2)];
      SRC_SUR, SRC_INV_SUR: g2 = gains.csine[gain_lane(sel2)];
      default:              g2 = gains.sine[gain_lane(sel2)];
    endcase
  end

  assign p1 = 33'(vol) * 33'(g1);
  assign p2 = 33'(v1_r) * 33'(g2_r);
  assign p3 = 31'(v2_r) * 31'(channel_level);

  assign v2_nxt  = (p2[32:14] > 19'(ONE_Q14)) ? 15'(ONE_Q14) : p2[28:14];
  assign out_nxt = on2_r ? p3[29:14] : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      on1_r <= slot_cfg[6];
      v1_r  <= p1[31:14];
      g2_r  <= g2;
      on2_r <= on1_r;
      v2_r  <= v2_nxt;
      out_r <= out_nxt;
    end
  end

  assign bus_volume = out_r;

endmodule

// ===== sv/channel_mixer_volume_calc.sv =====
// Per-voice bus mixer volume calculator, top level.
// Path: input accept to result valid through the level, gain-lane and bus-slot stages.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: rst_n synchronous active low; clears valid bits and loads register defaults.
`timescale 1ns / 1ps
module channel_mixer_volume_calc
  import cmvc_pkg::*;
#(
  parameter int SLOT_COUNT       = 6,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  cmvc_in_if.sink          in_ch,
  cmvc_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int LAT = 8;

  logic [47:0] sound_levels_r, channel_levels_r, power_weights_r;
  logic [16:0] calc_types_r;
  logic [41:0] mix_slots_r;
  logic [15:0] volume_gain_r, channel_level_r;
  logic [LAT-1:0] vld_r;
  logic en;
  levels_t lv;
  gains_t  gains;
  vol_t    vol;
  vol_t    vol_d_r [3];
  logic [15:0] bus [NUM_OUT];

  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sound_levels_r   <= 48'd8192;
      channel_levels_r <= 48'd8192;
      power_weights_r  <= '0;
      calc_types_r     <= 17'd33850;
      mix_slots_r      <= 42'd156935272;
      volume_gain_r    <= 16'd16384;
      channel_level_r  <= 16'd32767;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SOUND_LEVELS:   sound_levels_r   <= cfg_wdata;
        CFG_CHANNEL_LEVELS: channel_levels_r <= cfg_wdata;
        CFG_POWER_WEIGHTS:  power_weights_r  <= cfg_wdata;
        CFG_CALC_TYPES:     calc_types_r     <= cfg_wdata[16:0];
        CFG_MIX_SLOTS:      mix_slots_r      <= cfg_wdata[41:0];
        CFG_VOLUME_GAIN:    volume_gain_r    <= cfg_wdata[15:0];
        CFG_CHANNEL_LEVEL:  channel_level_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vol_d_r[0] <= vol;
      vol_d_r[1] <= vol_d_r[0];
      vol_d_r[2] <= vol_d_r[1];
    end
  end

  cmvc_level u_level (
    .clk            (clk),
    .en             (en),
    .osc_volume     (in_ch.osc_volume),
    .osc_pan        (in_ch.osc_pan),
    .osc_fxmix      (in_ch.osc_fxmix),
    .osc_surround   (in_ch.osc_surround),
    .sound_levels   (sound_levels_r),
    .channel_levels (channel_levels_r),
    .power_weights  (power_weights_r),
    .calc_types     (calc_types_r),
    .volume_gain    (volume_gain_r),
    .lv             (lv),
    .vol            (vol)
  );

  cmvc_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine (
    .clk   (clk),
    .en    (en),
    .lv    (lv),
    .gains (gains)
  );

  for (genvar i = 0; i < NUM_OUT; i++) begin : g_slot
    if (i < SLOT_COUNT) begin : g_on
      cmvc_slot u_slot (
        .clk           (clk),
        .en            (en),
        .slot_cfg      (mix_slots_r[7*i +: 7]),
        .gains         (gains),
        .vol           (vol_d_r[2]),
        .channel_level (channel_level_r),
        .bus_volume    (bus[i])
      );
    end else begin : g_off
      assign bus[i] = '0;
    end
  end

  assign out_ch.valid        = vld_r[LAT-1];
  assign out_ch.bus_volume_0 = bus[0];
  assign out_ch.bus_volume_1 = bus[1];
  assign out_ch.bus_volume_2 = bus[2];
  assign out_ch.bus_volume_3 = bus[3];
  assign out_ch.bus_volume_4 = bus[4];
  assign out_ch.bus_volume_5 = bus[5];

endmodule
